@@ hdl/pta_pkg.sv @@
package pta_pkg;

  // Field widths.
  localparam int SAMPLE_W = 8;
  localparam int LEVEL_W  = 7;
  localparam int CFG_IDX_W = 8;

  // Attenuation that means mute.
  localparam logic [LEVEL_W-1:0] MUTE_DB = 7'd64;

  // Guard values after reset.
  localparam logic [SAMPLE_W-1:0] LOW_GUARD_RESET  = 8'd15;
  localparam logic [SAMPLE_W-1:0] HIGH_GUARD_RESET = 8'hD0;

  // Division by three of an 8-bit value: (x * 171) >> 9 is exact for x below 512.
  localparam logic [SAMPLE_W-1:0] DIV3_RECIP = 8'd171;
  localparam int DIV3_SHIFT = 9;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LOW_GUARD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GUARD = 8'd1;

  // A target level travelling from the classifier into the queue.
  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
  } level_req_t;

endpackage

@@ hdl/pot_to_attenuation_ramp_unit.sv @@
// Maps each volume-pot request to a target attenuation of 0 to 64 dB and emits every
// 1 dB level from the last applied level to that target, the target flagged as last.
// A request is classified in the cycle it is taken and placed in a queue of QUEUE_DEPTH
// targets. The stepper takes a target from the queue when idle and then produces
// one level per cycle while the output is taken, so a request yields
// |target - previous level| levels. A request whose target equals the kept level
// produces nothing. Guard registers are index 0 (low guard) and index 1 (high guard);
// writes are always taken.
module pot_to_attenuation_ramp_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pta_pkg::SAMPLE_W-1:0]  in_pot_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pta_pkg::LEVEL_W-1:0]   out_atten_db,
  output logic                          out_last_step,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pta_pkg::SAMPLE_W-1:0]  cfg_data
);

  pta_pkg::level_req_t         push;
  logic                        q_full;
  logic                        q_empty;
  logic                        q_pop;
  logic [pta_pkg::LEVEL_W-1:0] q_head;

  // Classifier and guard registers.
  pta_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pot_sample (in_pot_sample),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .push          (push)
  );

  // Queue of targets between classifier and stepper.
  pta_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  // Stepper with output register.
  pta_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_atten_db  (out_atten_db),
    .out_last_step (out_last_step)
  );

endmodule

@@ hdl/pta_front.sv @@
module pta_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pta_pkg::SAMPLE_W-1:0]   in_pot_sample,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pta_pkg::SAMPLE_W-1:0]   cfg_data,
  input  logic                           q_full,
  output pta_pkg::level_req_t            push
);

  logic [pta_pkg::SAMPLE_W-1:0]   low_guard_r;
  logic [pta_pkg::SAMPLE_W-1:0]   high_guard_r;
  logic [pta_pkg::SAMPLE_W-1:0]   diff;
  logic [2*pta_pkg::SAMPLE_W-1:0] prod;
  logic [pta_pkg::LEVEL_W-1:0]    quot;
  logic [pta_pkg::LEVEL_W-1:0]    target;

  // Guard registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_guard_r  <= pta_pkg::LOW_GUARD_RESET;
      high_guard_r <= pta_pkg::HIGH_GUARD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == pta_pkg::REG_LOW_GUARD) begin
        low_guard_r <= cfg_data;
      end
      if (cfg_index == pta_pkg::REG_HIGH_GUARD) begin
        high_guard_r <= cfg_data;
      end
    end
  end

  // Map the sample to a target level. The quotient by three uses a reciprocal.
  assign diff = in_pot_sample - low_guard_r;
  assign prod = diff * pta_pkg::DIV3_RECIP;
  assign quot = prod[2*pta_pkg::SAMPLE_W-1:pta_pkg::DIV3_SHIFT];

  always_comb begin
    if (in_pot_sample < low_guard_r) begin
      target = pta_pkg::MUTE_DB;
    end else if (in_pot_sample >= high_guard_r) begin
      target = '0;
    end else if (quot >= pta_pkg::MUTE_DB) begin
      target = '0;
    end else begin
      target = pta_pkg::MUTE_DB - quot;
    end
  end

  // A request is taken whenever the queue has room.
  assign in_ready   = !q_full;
  assign push.valid = in_valid && !q_full;
  assign push.level = target;

endmodule

@@ hdl/pta_fifo.sv @@
module pta_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pta_pkg::level_req_t           push,
  input  logic                          pop,
  output logic                          full,
  output logic                          empty,
  output logic [pta_pkg::LEVEL_W-1:0]   head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [pta_pkg::LEVEL_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  // Storage of queued target levels.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.level;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/pta_back.sv @@
module pta_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  logic [pta_pkg::LEVEL_W-1:0]   q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pta_pkg::LEVEL_W-1:0]   out_atten_db,
  output logic                          out_last_step
);

  logic                        busy_r, busy_nxt;
  logic [pta_pkg::LEVEL_W-1:0] applied_r, applied_nxt;
  logic [pta_pkg::LEVEL_W-1:0] target_r, target_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [pta_pkg::LEVEL_W-1:0] atten_r, atten_nxt;
  logic                        last_r, last_nxt;
  logic                        load_ok;
  logic [pta_pkg::LEVEL_W-1:0] step;

  assign load_ok = !out_valid_r || out_ready;
  assign q_pop   = !busy_r && !q_empty;
  assign step    = (applied_r < target_r) ? applied_r + 1'b1 : applied_r - 1'b1;

  // Pop a target when idle; walk one dB per cycle towards it while output is taken.
  always_comb begin
    busy_nxt      = busy_r;
    applied_nxt   = applied_r;
    target_nxt    = target_r;
    out_valid_nxt = out_valid_r && !out_ready;
    atten_nxt     = atten_r;
    last_nxt      = last_r;
    if (q_pop) begin
      target_nxt = q_head;
      busy_nxt   = (q_head != applied_r);
    end
    if (busy_r && load_ok) begin
      applied_nxt   = step;
      atten_nxt     = step;
      last_nxt      = (step == target_r);
      out_valid_nxt = 1'b1;
      busy_nxt      = (step != target_r);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      applied_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      applied_r   <= applied_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    target_r <= target_nxt;
    atten_r  <= atten_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_atten_db  = atten_r;
  assign out_last_step = last_r;

`ifndef NO_ASSERTIONS
  // Levels shown never exceed mute.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> atten_r <= pta_pkg::MUTE_DB)
    else $error("attenuation level above mute");

  // While stepping, the target has not yet been reached.
  a_busy_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> applied_r != target_r)
    else $error("stepper busy at its target");

  // A run that is not finished continues with no gap.
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !last_r) |=> out_valid_r)
    else $error("gap inside a run of steps");

  // The kept level is always what was last shown.
  a_applied_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> applied_r == atten_r)
    else $error("kept level differs from shown level");
`endif

endmodule

@@ bench/pot_to_attenuation_ramp_unit_tb.sv @@
module pot_to_attenuation_ramp_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DB_PER_STEP  = 3;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 1000;

  typedef logic [pta_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic [pta_pkg::LEVEL_W-1:0]  level_t;

  // Index that decodes to no register; writes to it must leave the guards alone.
  localparam logic [pta_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'hFF;

  typedef struct packed {
    logic [pta_pkg::LEVEL_W-1:0] level;
    logic                        is_last;
  } atten_step_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [pta_pkg::SAMPLE_W-1:0]  in_pot_sample = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [pta_pkg::LEVEL_W-1:0]   out_atten_db;
  logic                          out_last_step;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [pta_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pta_pkg::SAMPLE_W-1:0]  cfg_data = '0;

  // Predictor state: guards and the level the unit last applied.
  logic [pta_pkg::SAMPLE_W-1:0] guard_lo = pta_pkg::LOW_GUARD_RESET;
  logic [pta_pkg::SAMPLE_W-1:0] guard_hi = pta_pkg::HIGH_GUARD_RESET;
  logic [pta_pkg::LEVEL_W-1:0]  kept_level = '0;

  logic [pta_pkg::SAMPLE_W-1:0] pot_backlog[$];
  atten_step_t                  steps_due[$];
  int                           samples_queued = 0;
  int                           samples_taken = 0;
  int                           mismatches = 0;
  int                           idle_pct = 0;
  int                           gap_left = 0;
  int                           stall_left = 0;
  int                           hold_left = 0;
  logic                         hold_off_req = 1'b0;
  logic                         hold_done = 1'b0;
  int                           quiet_cycles = 0;
  logic [pta_pkg::SAMPLE_W-1:0] last_sample = '0;

  pot_to_attenuation_ramp_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pot_sample(in_pot_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_atten_db (out_atten_db),
    .out_last_step(out_last_step),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Target attenuation for one pot reading under the current guards.
  function automatic level_t target_for(input sample_t s);
    int steps_down;
    if (s < guard_lo) return pta_pkg::MUTE_DB;
    if (s >= guard_hi) return '0;
    steps_down = int'(s - guard_lo) / DB_PER_STEP;
    if (steps_down >= int'(pta_pkg::MUTE_DB)) return '0;
    return pta_pkg::MUTE_DB - level_t'(steps_down);
  endfunction

  // Walks the kept level to the new target, one dB per expected step.
  function automatic void ramp_toward(input sample_t s);
    level_t      goal;
    atten_step_t st;
    goal = target_for(s);
    while (kept_level != goal) begin
      if (kept_level < goal) kept_level = kept_level + 1'b1;
      else kept_level = kept_level - 1'b1;
      st.level   = kept_level;
      st.is_last = (kept_level == goal);
      steps_due.push_back(st);
    end
  endfunction

  // Request driver: presents queued readings, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        ramp_toward(in_pot_sample);
        samples_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pot_backlog.size() != 0) begin
          if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            gap_left <= $urandom_range(6, 0);
          end else begin
            in_valid      <= 1'b1;
            in_pot_sample <= pot_backlog.pop_front();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each level against the oldest expected step and
  // drives the ready side, including one long hold-off on request.
  always @(posedge clk) begin
    atten_step_t st;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (steps_due.size() == 0) begin
          $error("unexpected result: atten_db %0d last_step %0b", out_atten_db, out_last_step);
          mismatches++;
        end else begin
          st = steps_due.pop_front();
          if (out_atten_db !== st.level) begin
            $error("atten_db: expected %0d, got %0d", st.level, out_atten_db);
            mismatches++;
          end
          if (out_last_step !== st.is_last) begin
            $error("last_step: expected %0b, got %0b", st.is_last, out_last_step);
            mismatches++;
          end
        end
      end
      if (hold_off_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_left <= $urandom_range(6, 0);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no channel moves anything for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic queue_sample(input sample_t s);
    pot_backlog.push_back(s);
    samples_queued++;
    last_sample = s;
  endtask

  // Half uniform readings, the other half aimed at the guard edges, the
  // clamp region, the rail values and repeats that must produce nothing.
  task automatic queue_random(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) queue_sample(sample_t'($urandom_range(255, 0)));
      else if (pick < 65) queue_sample(guard_lo + sample_t'($urandom_range(2, 0)) - 8'd1);
      else if (pick < 75) queue_sample(guard_hi + sample_t'($urandom_range(2, 0)) - 8'd1);
      else if (pick < 83) queue_sample(last_sample);
      else if (pick < 91) queue_sample($urandom_range(1) ? 8'hFF : 8'h00);
      else queue_sample(guard_lo + sample_t'($urandom_range(197, 188)));
    end
  endtask

  // Waits for every request to be taken and every step to arrive, then settles.
  task automatic wait_idle();
    while (samples_taken != samples_queued || steps_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pta_pkg::CFG_IDX_W-1:0] idx, input sample_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == pta_pkg::REG_LOW_GUARD) guard_lo = val;
    else if (idx == pta_pkg::REG_HIGH_GUARD) guard_hi = val;
  endtask

  task automatic set_guards(input sample_t lo, input sample_t hi);
    wait_idle();
    write_reg(pta_pkg::REG_LOW_GUARD, lo);
    write_reg(pta_pkg::REG_HIGH_GUARD, hi);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset guards: full swings both ways, guard edges, clamp and repeats.
    idle_pct = 25;
    queue_sample(8'd0);
    queue_sample(8'd255);
    queue_sample(8'd14);
    queue_sample(8'd15);
    queue_sample(8'd16);
    queue_sample(8'd18);
    queue_sample(8'd207);
    queue_sample(8'd208);
    queue_sample(8'd100);
    queue_sample(8'd100);
    queue_sample(8'h55);
    queue_sample(8'hAA);
    queue_sample(8'd1);
    queue_sample(8'd254);

    // Widest guards: the quotient passes 64 and the target clamps to zero.
    set_guards(8'd0, 8'd255);
    queue_sample(8'd0);
    queue_sample(8'd192);
    queue_sample(8'd60);
    queue_sample(8'd254);
    queue_sample(8'd255);

    // Crossed guards: the low guard wins, everything else gives zero.
    set_guards(8'd200, 8'd50);
    queue_sample(8'd199);
    queue_sample(8'd200);
    queue_sample(8'd0);
    queue_sample(8'd120);
    wait_idle();

    // A write to an unused index must not disturb the guards.
    write_reg(REG_SPARE, 8'd0);
    queue_random(30);

    set_guards(8'd255, 8'd0);
    idle_pct = 0;
    queue_random(25);

    set_guards(8'd0, 8'd0);
    idle_pct = 40;
    queue_random(20);

    // Random guards; the receiver holds off while requests keep coming, then
    // the sender pauses until the unit has fully drained.
    set_guards(sample_t'($urandom_range(80, 0)), sample_t'($urandom_range(255, 120)));
    idle_pct = 15;
    queue_random(25);
    @(posedge clk);
    hold_off_req <= 1'b1;
    while (!hold_done) @(posedge clk);
    wait_idle();
    queue_random(25);

    set_guards(pta_pkg::LOW_GUARD_RESET, pta_pkg::HIGH_GUARD_RESET);
    idle_pct = 30;
    queue_random(40);

    set_guards(sample_t'($urandom_range(255, 0)), sample_t'($urandom_range(255, 0)));
    queue_random(30);

    // Closing stretch at full rate on both sides.
    set_guards(8'd60, 8'd180);
    idle_pct = 0;
    queue_random(40);

    wait_idle();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pta_pkg.sv
hdl/pta_front.sv
hdl/pta_fifo.sv
hdl/pta_back.sv
hdl/pot_to_attenuation_ramp_unit.sv
bench/pot_to_attenuation_ramp_unit_tb.sv
